[hw/rtl/text_console_cell_writer_top_macros.svh]
// Assertion macros for the text console cell writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_MACROS_SVH

// condition that must hold at every edge
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tcw_pkg.sv]
// Package: constants, types and codes of the text console cell writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int SUM_W      = ADDR_W + 1;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {ATTR_RESET, BLANK_CHAR};

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_PUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] limit;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             hit;
    } alu_rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] data;
    } res_t;

endpackage

[hw/rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/tcw_alu.sv]
// Shared address adder with end-of-walk compare.
module tcw_alu (
    input  tcw_pkg::alu_req_t req,
    output tcw_pkg::alu_rsp_t rsp
);
    import tcw_pkg::*;

    always_comb
    begin
        rsp.sum = req.a + req.b;
        rsp.hit = (rsp.sum == req.limit);
    end

endmodule

[hw/rtl/tcw_seq.sv]
// Sequencer: cursor, command decode, cell read, scroll, fill and cell write steps.
module tcw_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                in_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0] in_char,
    input  logic [tcw_pkg::ADDR_W-1:0] in_idx,
    input  logic [tcw_pkg::ATTR_W-1:0] attr,
    input  logic                      out_free,
    output logic                      res_load,
    output tcw_pkg::res_t             res,
    output tcw_pkg::ram_req_t         ram_req,
    input  logic [tcw_pkg::CELL_W-1:0] ram_rdata,
    output tcw_pkg::alu_req_t         alu_req,
    input  tcw_pkg::alu_rsp_t         alu_rsp
);
    import tcw_pkg::*;

    localparam logic [SUM_W-1:0] SUM_ONE    = SUM_W'(1);
    localparam logic [SUM_W-1:0] SUM_COLS   = SUM_W'(COLUMNS);
    localparam logic [SUM_W-1:0] SUM_CELLS  = SUM_W'(CELLS);
    localparam logic [SUM_W-1:0] SUM_SHIFT  = SUM_W'(COLUMNS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(COLUMNS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] IDX_LIMIT = ADDR_W'(CELLS);
    localparam logic [COL_W-1:0] COL_WRAP   = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               put_after_reg;
    op_t                op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [CELL_W-1:0]  data_reg;
    logic               is_nul;
    logic               is_newline;
    logic               wrap;
    logic [SUM_W-1:0]   row_base;

    assign is_nul     = (char_reg == NUL_CHAR);
    assign is_newline = (char_reg == NEWLINE_CHAR);
    assign wrap       = (col_reg >= COL_WRAP) || is_newline;
    assign row_base   = SUM_W'(row_reg) * SUM_COLS;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (alu_rsp.hit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_PUT:
                    begin
                        priority if (is_nul)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (wrap && (row_reg == ROW_LAST))
                        begin
                            state_next = ST_SCROLL_RD;
                        end
                        else if (is_newline)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                    OP_READ:
                    begin
                        state_next = (idx_reg < IDX_LIMIT) ? ST_READ_WAIT : ST_DONE;
                    end
                    OP_CLEAR: state_next = ST_FILL;
                    OP_NONE:  state_next = ST_DONE;
                endcase
            end
            ST_READ_WAIT: state_next = ST_DONE;
            ST_SCROLL_RD: state_next = ST_SCROLL_WR;
            ST_SCROLL_WR:
            begin
                if (alu_rsp.hit)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_SCROLL_RD;
                end
            end
            ST_FILL:
            begin
                if (alu_rsp.hit)
                begin
                    state_next = put_after_reg ? ST_PUT : ST_DONE;
                end
            end
            ST_PUT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        alu_req.a     = {SUM_W{1'b0}};
        alu_req.b     = {SUM_W{1'b0}};
        alu_req.limit = SUM_CELLS;
        ram_req.we    = 1'b0;
        ram_req.waddr = cnt_reg;
        ram_req.wdata = {attr, BLANK_CHAR};
        ram_req.raddr = idx_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                alu_req.a     = SUM_W'(cnt_reg);
                alu_req.b     = SUM_ONE;
                ram_req.we    = 1'b1;
                ram_req.wdata = RESET_CELL;
            end
            ST_FILL:
            begin
                alu_req.a     = SUM_W'(cnt_reg);
                alu_req.b     = SUM_ONE;
                ram_req.we    = 1'b1;
            end
            ST_SCROLL_RD:
            begin
                alu_req.a     = SUM_W'(cnt_reg);
                alu_req.b     = SUM_COLS;
                ram_req.raddr = alu_rsp.sum[ADDR_W-1:0];
            end
            ST_SCROLL_WR:
            begin
                alu_req.a     = SUM_W'(cnt_reg);
                alu_req.b     = SUM_ONE;
                alu_req.limit = SUM_SHIFT;
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata;
            end
            ST_PUT:
            begin
                alu_req.a     = row_base;
                alu_req.b     = SUM_W'(col_reg);
                ram_req.we    = 1'b1;
                ram_req.waddr = alu_rsp.sum[ADDR_W-1:0];
                ram_req.wdata = {attr, char_reg};
            end
            default:
            begin
                alu_req.a     = {SUM_W{1'b0}};
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign res_load = (state_reg == ST_DONE) && out_free;
    assign res      = '{row: row_reg, col: col_reg, data: data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= {ADDR_W{1'b0}};
            col_reg       <= {COL_W{1'b0}};
            row_reg       <= {ROW_W{1'b0}};
            put_after_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_INIT, ST_FILL:
                begin
                    cnt_reg <= alu_rsp.sum[ADDR_W-1:0];
                end
                ST_EXEC:
                begin
                    if (op_reg == OP_PUT && !is_nul && wrap)
                    begin
                        col_reg <= {COL_W{1'b0}};
                        if (row_reg == ROW_LAST)
                        begin
                            cnt_reg       <= {ADDR_W{1'b0}};
                            put_after_reg <= !is_newline;
                        end
                        else
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end
                    else if (op_reg == OP_CLEAR)
                    begin
                        cnt_reg       <= {ADDR_W{1'b0}};
                        put_after_reg <= 1'b0;
                    end
                end
                ST_SCROLL_WR:
                begin
                    cnt_reg <= alu_rsp.hit ? LAST_ROW_BASE : alu_rsp.sum[ADDR_W-1:0];
                end
                ST_PUT:
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg   <= op_t'(in_opcode);
            char_reg <= in_char;
            idx_reg  <= in_idx;
        end
        if (state_reg == ST_EXEC)
        begin
            data_reg <= {CELL_W{1'b0}};
        end
        else if (state_reg == ST_READ_WAIT)
        begin
            data_reg <= ram_rdata;
        end
    end

endmodule

[hw/rtl/text_console_cell_writer_top.sv]
// Top level of the text console cell writer.
//
// 80x25 screen of 16-bit cells (attribute byte high, character low) with a cursor.
// Input beats on s_*: put character, read cell or clear screen. Each beat gives
// one output beat on m_* with the read cell (zero unless a read) and the cursor.
// cfg_we/cfg_wdata set the attribute byte; write it only while the block is idle.
// From accept, an ignored character, a newline without scroll, an out-of-range read
// or the unused opcode goes from decode straight to the result; a put adds a cell
// write step and a read a read-wait step. A scroll copies 1920 cells through the
// single RAM read port, a read step and a write step per cell, and blanks 80 cells,
// then writes the character unless it was a newline; a clear writes 2000 cells. One
// beat is worked at a time: s_tready is low from accept until the result is in the
// output register and rises in the same cycle that the result appears there.
// After reset the block writes 0x0720 to all 2000 cells with s_tready low; the
// attribute resets to 0x07.
// A stalled m_tready holds the result in the output register; the next beat is
// accepted meanwhile and its result waits until the register is free.
`include "text_console_cell_writer_top_macros.svh"

module text_console_cell_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], char_code[9:2], cell_index[20:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cell_data[15:0], cursor_col[22:16], cursor_row[27:23]
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              out_valid_reg;
    res_t              out_reg;
    logic              out_free;
    logic              res_load;
    res_t              res;
    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    assign out_free = !out_valid_reg || m_tready;

    tcw_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    tcw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tdata[1:0]),
        .in_char   (s_tdata[9:2]),
        .in_idx    (s_tdata[20:10]),
        .attr      (attr_reg),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.row, out_reg.col, out_reg.data};

    `TCW_ASSERT_ALWAYS(a_row_range, !m_tvalid || (out_reg.row <= ROW_W'(ROWS - 1)), "row range")
    `TCW_ASSERT_ALWAYS(a_col_range, !m_tvalid || (out_reg.col <= COL_W'(COLUMNS)), "column range")
    `TCW_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "ready after beat")

endmodule
